FILE: rtl/rsd_pkg.sv
// shared types and constants for the rms silence detector
package rsd_pkg;

  localparam int unsigned MAX_FRAME      = 4096;
  localparam int unsigned MAX_CAL_FRAMES = 65535;

  // input op codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_LEVEL = 2'd0;
  localparam logic [1:0] KIND_STOP  = 2'd1;
  localparam logic [1:0] KIND_THR   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_DETECT_EN  = 3'd0;
  localparam logic [2:0] REG_CAL_EN     = 3'd1;
  localparam logic [2:0] REG_THRESHOLD  = 3'd2;
  localparam logic [2:0] REG_HOLD_MS    = 3'd3;
  localparam logic [2:0] REG_CAL_MS     = 3'd4;
  localparam logic [2:0] REG_OFFSET     = 3'd5;
  localparam logic [2:0] REG_DELAY_MS   = 3'd6;

  // iterative unit
  localparam int unsigned DIV_STEPS  = 44;
  localparam int unsigned SQRT_STEPS = 22;

  typedef enum logic {ARITH_DIV, ARITH_SQRT} arith_mode_t;

  typedef struct packed {
    logic        start;
    arith_mode_t mode;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CLOSE,
    ST_DIV_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_CAL,
    ST_CAL_WAIT,
    ST_EMIT
  } rsd_state_t;

  // a zero duration acts as one
  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

FILE: rtl/rms_silence_detector.sv
// top level of the rms silence detector
//
// Input beats on s_*: s_tuser is the op (sample, millisecond tick, start),
// s_tdata the signed sample, s_tlast the frame end marker. Result beats on
// m_*: m_tuser is the kind (frame level, silence stop, calibrated threshold),
// m_tdata carries rms level, silent flag and new threshold, m_tlast marks the
// final result of one input beat. Registers are to be written on cfg_* only
// while idle; the block itself does not enforce this. One beat is handled
// at a time; s_tready is high only when idle. A sample is squared
// bit-serially (16x16, one bit per cycle). A frame end adds the divide and
// the square root in the shared iterative unit. A tick that closes the
// calibration window adds a divide of the level sum by the frame count.
// The output register holds one result; the next input beat is taken while
// it waits, and a new result stalls until the receiver takes the old one.
// Reset is synchronous: registers go to their reset values, the countdowns,
// frame counters and accumulators clear, and no result is pending.
module rms_silence_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [15:0] sample
  input  logic [1:0]  s_tuser,  // [1:0] op
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [15:0] rms_level, [16] is_silent, [33:17] new_threshold
  output logic [1:0]  m_tuser,  // [1:0] kind
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import rsd_pkg::*;

  // registers
  logic        detect_enable, calibrate_enable;
  logic [16:0] silence_threshold;
  logic [15:0] silence_hold_ms, calibrate_ms, threshold_offset;
  logic [9:0]  start_delay_ms;

  // state
  rsd_state_t  state, state_next;
  logic [42:0] square_sum;
  logic [12:0] frame_samples;
  logic [16:0] working_threshold;
  logic        detect_running, calib_running;
  logic [15:0] hold_countdown, calib_countdown;
  logic [31:0] level_sum;
  logic [15:0] frames_seen;
  logic [9:0]  delay_left;
  logic        pend_hold, pend_cal;
  logic        cal_todo;

  // current sample work
  logic        frame_end;
  logic [31:0] mcand;
  logic [15:0] mplier;
  logic [3:0]  sq_cnt;

  // staged result
  logic [1:0]  res_kind;
  logic [15:0] res_rms;
  logic        res_silent;
  logic [16:0] res_thr;
  logic        res_last;

  arith_req_t  areq;
  arith_rsp_t  arsp;
  logic [43:0] a_op;
  logic [15:0] b_op;
  logic [42:0] a_res;

  logic        in_beat, out_free;
  logic        stop_fire, cal_fire, add_ok;
  logic        level_fire;
  logic [15:0] rms_val;
  logic        rms_silent;
  logic [16:0] cal_thr;

  rsd_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (areq),
    .a      (a_op),
    .b      (b_op),
    .rsp    (arsp),
    .result (a_res)
  );

  assign in_beat   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign add_ok    = frame_samples < 13'(MAX_FRAME);

  // tick events
  assign stop_fire = (hold_countdown == 16'd1) && detect_running;
  assign cal_fire  = (calib_countdown == 16'd1) && calib_running;

  // frame level once the root is known, or zero for an empty frame
  always_comb begin
    level_fire = 1'b0;
    rms_val    = 16'd0;
    if (state == ST_CLOSE && frame_samples == 13'd0) begin
      level_fire = 1'b1;
    end else if (state == ST_ROOT_WAIT && arsp.done) begin
      level_fire = 1'b1;
      rms_val    = a_res[15:0];
    end
    rms_silent = {1'b0, rms_val} < working_threshold;
    cal_thr    = {1'b0, a_res[15:0]} + {1'b0, threshold_offset};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          if (s_tuser == OP_SAMPLE) begin
            if (add_ok) state_next = ST_SQUARE;
            else if (s_tlast) state_next = ST_CLOSE;
          end else if (s_tuser == OP_TICK) begin
            if (stop_fire) state_next = ST_EMIT;
            else if (cal_fire) state_next = ST_CAL;
          end
        end
      end
      ST_SQUARE: begin
        if (sq_cnt == 4'd15) state_next = frame_end ? ST_CLOSE : ST_IDLE;
      end
      ST_CLOSE: begin
        state_next = (frame_samples == 13'd0) ? ST_EMIT : ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (arsp.done) state_next = ST_ROOT_GO;
      end
      ST_ROOT_GO: state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (arsp.done) state_next = ST_EMIT;
      end
      ST_CAL: begin
        state_next = (frames_seen == 16'd0) ? ST_EMIT : ST_CAL_WAIT;
      end
      ST_CAL_WAIT: begin
        if (arsp.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = cal_todo ? ST_CAL : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready   = (state == ST_IDLE);
    areq.start = 1'b0;
    areq.mode  = ARITH_DIV;
    a_op       = {1'b0, square_sum};
    b_op       = {3'd0, frame_samples};
    unique case (state)
      ST_CLOSE: areq.start = (frame_samples != 13'd0);
      ST_ROOT_GO: begin
        areq.start = 1'b1;
        areq.mode  = ARITH_SQRT;
        a_op       = {1'b0, a_res};
      end
      ST_CAL: begin
        areq.start = (frames_seen != 16'd0);
        a_op       = {12'd0, level_sum};
        b_op       = frames_seen;
      end
      default: begin
      end
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_enable     <= 1'b0;
      calibrate_enable  <= 1'b0;
      silence_threshold <= 17'd0;
      silence_hold_ms   <= 16'd1000;
      calibrate_ms      <= 16'd3000;
      threshold_offset  <= 16'd500;
      start_delay_ms    <= 10'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DETECT_EN: detect_enable     <= cfg_data[0];
        REG_CAL_EN:    calibrate_enable  <= cfg_data[0];
        REG_THRESHOLD: silence_threshold <= cfg_data;
        REG_HOLD_MS:   silence_hold_ms   <= cfg_data[15:0];
        REG_CAL_MS:    calibrate_ms      <= cfg_data[15:0];
        REG_OFFSET:    threshold_offset  <= cfg_data[15:0];
        REG_DELAY_MS:  start_delay_ms    <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // sample capture and bit-serial squaring
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_beat) begin
      frame_end <= s_tlast;
      mcand     <= {16'd0, (s_tdata[15] ? 16'(-s_tdata) : s_tdata)};
      mplier    <= s_tdata[15] ? 16'(-s_tdata) : s_tdata;
      sq_cnt    <= 4'd0;
    end else if (state == ST_SQUARE) begin
      mcand  <= {mcand[30:0], 1'b0};
      mplier <= {1'b0, mplier[15:1]};
      sq_cnt <= sq_cnt + 4'd1;
    end
  end

  // control and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      square_sum        <= '0;
      frame_samples     <= '0;
      working_threshold <= '0;
      detect_running    <= 1'b0;
      calib_running     <= 1'b0;
      hold_countdown    <= '0;
      calib_countdown   <= '0;
      level_sum         <= '0;
      frames_seen       <= '0;
      delay_left        <= '0;
      pend_hold         <= 1'b0;
      pend_cal          <= 1'b0;
      cal_todo          <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      state <= state_next;

      // input beat
      if (state == ST_IDLE && in_beat) begin
        unique case (s_tuser)
          OP_SAMPLE: begin
            if (add_ok) frame_samples <= frame_samples + 13'd1;
          end
          OP_TICK: begin
            if (stop_fire) detect_running <= 1'b0;
            if (cal_fire) calib_running <= 1'b0;
            cal_todo <= cal_fire;
            if (stop_fire) begin
              res_kind   <= KIND_STOP;
              res_rms    <= 16'd0;
              res_silent <= 1'b0;
              res_thr    <= 17'd0;
              res_last   <= !cal_fire;
            end
            // countdowns step, a start delay running out loads them
            if (delay_left == 10'd1 && pend_hold && detect_running && !stop_fire)
              hold_countdown <= at_least_one(silence_hold_ms);
            else if (hold_countdown != 16'd0)
              hold_countdown <= hold_countdown - 16'd1;
            if (delay_left == 10'd1 && pend_cal && calib_running && !cal_fire)
              calib_countdown <= at_least_one(calibrate_ms);
            else if (calib_countdown != 16'd0)
              calib_countdown <= calib_countdown - 16'd1;
            if (delay_left != 10'd0) delay_left <= delay_left - 10'd1;
            if (delay_left == 10'd1) begin
              pend_hold <= 1'b0;
              pend_cal  <= 1'b0;
            end
          end
          OP_START: begin
            if (detect_enable) begin
              detect_running    <= 1'b1;
              working_threshold <= silence_threshold;
            end
            if (calibrate_enable) calib_running <= 1'b1;
            if (detect_enable || calibrate_enable) begin
              delay_left <= start_delay_ms;
              if (start_delay_ms == 10'd0) begin
                if ((pend_hold || detect_enable) && (detect_running || detect_enable))
                  hold_countdown <= at_least_one(silence_hold_ms);
                if ((pend_cal || calibrate_enable) && (calib_running || calibrate_enable))
                  calib_countdown <= at_least_one(calibrate_ms);
                pend_hold <= 1'b0;
                pend_cal  <= 1'b0;
              end else begin
                if (detect_enable) pend_hold <= 1'b1;
                if (calibrate_enable) pend_cal <= 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end

      // one partial product per cycle
      if (state == ST_SQUARE && mplier[0])
        square_sum <= square_sum + {11'd0, mcand};

      // frame closes
      if (level_fire) begin
        square_sum    <= '0;
        frame_samples <= '0;
        if (detect_running && (!rms_silent || hold_countdown == 16'd0))
          hold_countdown <= at_least_one(silence_hold_ms);
        if (calib_running && frames_seen < 16'(MAX_CAL_FRAMES)) begin
          level_sum   <= level_sum + {16'd0, rms_val};
          frames_seen <= frames_seen + 16'd1;
        end
        res_kind   <= KIND_LEVEL;
        res_rms    <= rms_val;
        res_silent <= rms_silent;
        res_thr    <= 17'd0;
        res_last   <= 1'b1;
      end

      // calibration window closes
      if (state == ST_CAL && frames_seen == 16'd0) begin
        cal_todo   <= 1'b0;
        res_kind   <= KIND_THR;
        res_rms    <= 16'd0;
        res_silent <= 1'b0;
        res_thr    <= 17'd0;
        res_last   <= 1'b1;
      end
      if (state == ST_CAL_WAIT && arsp.done) begin
        cal_todo          <= 1'b0;
        working_threshold <= cal_thr;
        level_sum         <= '0;
        frames_seen       <= '0;
        res_kind          <= KIND_THR;
        res_rms           <= 16'd0;
        res_silent        <= 1'b0;
        res_thr           <= cal_thr;
        res_last          <= 1'b1;
      end

      // hand the staged result to the output register
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
        m_tuser  <= res_kind;
        m_tlast  <= res_last;
        m_tdata  <= {6'd0, res_thr, res_silent, res_rms};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("input taken while busy");
  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    frame_samples <= 13'(MAX_FRAME)) else $error("frame count past limit");
  a_stop_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_STOP) |-> (m_tdata == 40'd0))
    else $error("stop result carries data");
  a_emit_follows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |=> m_tvalid) else $error("result lost");

endmodule

FILE: rtl/rsd_arith.sv
// shared iterative unit: restoring divide and digit-by-digit square root
module rsd_arith (
  input  logic              clk,
  input  logic              rst,
  input  rsd_pkg::arith_req_t req,
  input  logic [43:0]       a,
  input  logic [15:0]       b,
  output rsd_pkg::arith_rsp_t rsp,
  output logic [42:0]       result
);
  import rsd_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  arith_mode_t mode;
  logic [43:0] w;
  logic [24:0] r;
  logic [21:0] q;
  logic [15:0] dsr;

  logic [16:0] dcand;
  logic        dge;
  logic [24:0] scand;
  logic [24:0] strial;
  logic        sge;

  // one quotient bit or one root bit per cycle
  always_comb begin
    dcand  = {r[15:0], w[43]};
    dge    = dcand >= {1'b0, dsr};
    scand  = {r[22:0], w[43:42]};
    strial = {1'b0, q, 2'b01};
    sge    = scand >= strial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        mode <= req.mode;
        w    <= a;
        r    <= '0;
        q    <= '0;
        dsr  <= b;
        cnt  <= (req.mode == ARITH_DIV) ? 6'(DIV_STEPS - 1) : 6'(SQRT_STEPS - 1);
      end else if (busy) begin
        if (mode == ARITH_DIV) begin
          r <= {9'd0, (dge ? 16'(dcand - {1'b0, dsr}) : dcand[15:0])};
          w <= {w[42:0], dge};
        end else begin
          r <= sge ? (scand - strial) : scand;
          q <= {q[20:0], sge};
          w <= {w[41:0], 2'b00};
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign result   = (mode == ARITH_DIV) ? w[42:0] : {21'd0, q};

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("arith started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("arith done while busy");
  a_rem_small: assert property (@(posedge clk) disable iff (rst)
    (busy && mode == ARITH_DIV) |-> (r[15:0] < dsr && r[24:16] == 9'd0))
    else $error("remainder not below divisor");

endmodule

FILE: bench/rsd_checker.sv
// result predictor and comparator for the rms silence detector
module rsd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          results_seen
);
  import rsd_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] rms;
    logic        silent;
    logic [16:0] thr;
    logic        last;
  } result_t;

  result_t expected_q[$];

  // register copies
  logic        det_en, cal_en;
  logic [16:0] thr_reg;
  logic [15:0] hold_ms, cal_ms, offset;
  logic [9:0]  delay_ms;

  // block state
  longint unsigned sq_sum, lvl_sum;
  int unsigned     nsamp, nframes, hold_cnt, cal_cnt, delay_left;
  logic [16:0]     wthr;
  bit              det_run, cal_run, pend_hold, pend_cal;

  assign pending = expected_q.size();

  // bitwise integer square root
  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic int unsigned nonzero(input logic [15:0] v);
    return (v == 16'd0) ? 1 : v;
  endfunction

  function automatic void add_result(input logic [1:0] kind, input logic [15:0] rms,
                                     input logic silent, input logic [16:0] thr);
    result_t r;
    r.kind = kind;
    r.rms = rms;
    r.silent = silent;
    r.thr = thr;
    r.last = 1'b1;
    expected_q = {expected_q, r};
  endfunction

  function automatic void load_countdowns();
    if (pend_hold && det_run) hold_cnt = nonzero(hold_ms);
    if (pend_cal && cal_run) cal_cnt = nonzero(cal_ms);
    pend_hold = 0;
    pend_cal = 0;
  endfunction

  // work out the results of one input beat
  function automatic void predict(input logic [1:0] op, input logic [15:0] smp,
                                  input logic fend);
    longint signed s;
    longint unsigned rms, thr;
    logic silent;
    int n;
    n = 0;
    if (op == OP_SAMPLE) begin
      s = $signed(smp);
      if (nsamp < MAX_FRAME) begin
        sq_sum += s * s;
        nsamp++;
      end
      if (fend) begin
        rms = (nsamp != 0) ? int_root(sq_sum / nsamp) : 0;
        sq_sum = 0;
        nsamp = 0;
        silent = (rms < wthr);
        if (det_run && (!silent || hold_cnt == 0)) hold_cnt = nonzero(hold_ms);
        if (cal_run && nframes < MAX_CAL_FRAMES) begin
          lvl_sum += rms;
          nframes++;
        end
        add_result(KIND_LEVEL, rms[15:0], silent, '0);
        n++;
      end
    end else if (op == OP_TICK) begin
      if (hold_cnt != 0) begin
        hold_cnt--;
        if (hold_cnt == 0 && det_run) begin
          det_run = 0;
          add_result(KIND_STOP, '0, 1'b0, '0);
          n++;
        end
      end
      if (cal_cnt != 0) begin
        cal_cnt--;
        if (cal_cnt == 0 && cal_run) begin
          cal_run = 0;
          thr = 0;
          if (nframes != 0) begin
            thr = (lvl_sum / nframes) + offset;
            wthr = thr[16:0];
            lvl_sum = 0;
            nframes = 0;
          end
          // a stop on the same tick is no longer the final result
          if (n > 0) expected_q[$].last = 1'b0;
          add_result(KIND_THR, '0, 1'b0, thr[16:0]);
          n++;
        end
      end
      if (delay_left != 0) begin
        delay_left--;
        if (delay_left == 0) load_countdowns();
      end
    end else if (op == OP_START) begin
      if (det_en) begin
        det_run = 1;
        wthr = thr_reg;
        pend_hold = 1;
      end
      if (cal_en) begin
        cal_run = 1;
        pend_cal = 1;
      end
      if (det_en || cal_en) begin
        delay_left = delay_ms;
        if (delay_left == 0) load_countdowns();
      end
    end
  endfunction

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  // watch all three channels
  always @(posedge clk) begin
    result_t r;
    if (rst) begin
      expected_q.delete();
      fails = 0;
      results_seen = 0;
      det_en = 0; cal_en = 0; thr_reg = 0;
      hold_ms = 1000; cal_ms = 3000; offset = 500; delay_ms = 100;
      sq_sum = 0; lvl_sum = 0; nsamp = 0; nframes = 0;
      hold_cnt = 0; cal_cnt = 0; delay_left = 0; wthr = 0;
      det_run = 0; cal_run = 0; pend_hold = 0; pend_cal = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DETECT_EN: det_en = cfg_data[0];
          REG_CAL_EN:    cal_en = cfg_data[0];
          REG_THRESHOLD: thr_reg = cfg_data;
          REG_HOLD_MS:   hold_ms = cfg_data[15:0];
          REG_CAL_MS:    cal_ms = cfg_data[15:0];
          REG_OFFSET:    offset = cfg_data[15:0];
          REG_DELAY_MS:  delay_ms = cfg_data[9:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: kind %0d", m_tuser);
          fails++;
        end else begin
          r = expected_q.pop_front();
          check_field("kind", r.kind, m_tuser);
          check_field("rms_level", r.rms, m_tdata[15:0]);
          check_field("is_silent", r.silent, m_tdata[16]);
          check_field("new_threshold", r.thr, m_tdata[33:17]);
          check_field("last", r.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) predict(s_tuser, s_tdata, s_tlast);
    end
  end

endmodule

FILE: bench/tb.sv
// stimulus and verdict for the rms silence detector
module tb;
  import rsd_pkg::*;

  // op code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_TICK;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  int fails, pending, results_seen;
  int beats_sent = 0;
  bit gaps_on = 0;
  bit long_hold_req = 0;

  always #5 clk = ~clk;

  rms_silence_detector dut (.*);

  rsd_checker chk (.*);

  // receiver: random stall bursts plus one long hold-off counted here
  always @(negedge clk) begin
    int burst;
    int hold_left;
    bit hold_used;
    if (long_hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (burst > 0) begin
      burst--;
      m_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      burst = $urandom_range(1, 17) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send(input logic [1:0] op, input logic [15:0] smp, input logic fend);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = smp;
    s_tlast = fend;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // let the block drain, then rewrite every register
  task automatic set_regs(input logic de, input logic ce, input logic [16:0] thr,
                          input logic [15:0] hold, input logic [15:0] cal,
                          input logic [15:0] off, input logic [9:0] dly);
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending == 0);
    repeat (120) @(posedge clk);
    write_reg(REG_DETECT_EN, {16'd0, de});
    write_reg(REG_CAL_EN, {16'd0, ce});
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_HOLD_MS, {1'b0, hold});
    write_reg(REG_CAL_MS, {1'b0, cal});
    write_reg(REG_OFFSET, {1'b0, off});
    write_reg(REG_DELAY_MS, {7'd0, dly});
  endtask

  // one random beat, mostly well-formed frames with ticks and starts between
  task automatic random_beat();
    int pick;
    logic [15:0] smp;
    pick = $urandom_range(0, 99);
    smp = 16'($urandom);
    if ($urandom_range(0, 2) == 0) smp = 16'($urandom_range(0, 600) - 300);
    if (pick < 60) send(OP_SAMPLE, smp, $urandom_range(0, 4) == 0);
    else if (pick < 90) send(OP_TICK, smp, 1'($urandom_range(0, 1)));
    else if (pick < 97) send(OP_START, smp, 1'($urandom_range(0, 1)));
    else send(OP_UNUSED, smp, 1'($urandom_range(0, 1)));
  endtask

  // settings for the random phases: detect, calibrate, threshold, hold, cal, offset, delay
  logic        ph_de  [5] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  logic        ph_ce  [5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  logic [16:0] ph_thr [5] = '{17'd200, 17'd131071, 17'd0, 17'd1000, 17'd5000};
  logic [15:0] ph_hold[5] = '{16'd4, 16'd0, 16'd65535, 16'd2, 16'd7};
  logic [15:0] ph_cal [5] = '{16'd6, 16'd0, 16'd1, 16'd3, 16'd9};
  logic [15:0] ph_off [5] = '{16'd0, 16'd65535, 16'd65535, 16'd100, 16'd500};
  logic [9:0]  ph_dly [5] = '{10'd0, 10'd3, 10'd1023, 10'd1, 10'd2};

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every op, restart, tick ordering
    set_regs(1'b1, 1'b1, 17'd20000, 16'd3, 16'd3, 16'd500, 10'd2);
    send(OP_START, 16'h0000, 1'b0);
    send(OP_SAMPLE, 16'h7fff, 1'b0);
    send(OP_SAMPLE, 16'h8000, 1'b1);
    send(OP_SAMPLE, 16'h8000, 1'b1);
    send(OP_SAMPLE, 16'h0000, 1'b1);
    send(OP_SAMPLE, 16'hffff, 1'b0);
    send(OP_SAMPLE, 16'h0001, 1'b1);
    send(OP_UNUSED, 16'hffff, 1'b1);
    send(OP_TICK, 16'h0000, 1'b0);
    send(OP_START, 16'hffff, 1'b1);
    repeat (6) send(OP_TICK, 16'h0000, 1'b0);
    send(OP_SAMPLE, 16'h0010, 1'b1);
    repeat (4) send(OP_TICK, 16'hffff, 1'b1);

    // random phases, the last one without idling
    for (int p = 0; p < 5; p++) begin
      set_regs(ph_de[p], ph_ce[p], ph_thr[p], ph_hold[p], ph_cal[p], ph_off[p], ph_dly[p]);
      gaps_on = (p < 4);
      if (p == 1) long_hold_req = 1'b1;
      for (int i = 0; i < 150; i++) begin
        if (p == 2 && i == 75) begin
          @(negedge clk);
          s_tvalid = 1'b0;
          wait (pending == 0);
        end
        random_beat();
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending == 0);
    repeat (150) @(posedge clk);
    $display("run covered %0d input beats and %0d result beats over 6 register settings",
             beats_sent, results_seen);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop
  initial begin
    #15000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
